// ===== hw/rtl/jnc_pkg.sv =====
package jnc_pkg;

  localparam int unsigned CharWidth = 8;

  localparam logic [3:0] PH_START      = 4'd0;
  localparam logic [3:0] PH_FIRST_DIG  = 4'd1;
  localparam logic [3:0] PH_INT_DONE   = 4'd2;
  localparam logic [3:0] PH_INT_DIGITS = 4'd3;
  localparam logic [3:0] PH_DOT        = 4'd4;
  localparam logic [3:0] PH_FRAC       = 4'd5;
  localparam logic [3:0] PH_EXP_MARK   = 4'd6;
  localparam logic [3:0] PH_EXP_SIGN   = 4'd7;
  localparam logic [3:0] PH_EXP_DIGITS = 4'd8;
  localparam logic [3:0] PH_SWALLOW    = 4'd9;

  localparam logic [1:0] V_OKAY    = 2'd0;
  localparam logic [1:0] V_INVALID = 2'd1;
  localparam logic [1:0] V_EARLY   = 2'd2;
  localparam logic [1:0] V_NONE    = 2'd3;

  localparam logic [1:0] K_ZERO    = 2'd0;
  localparam logic [1:0] K_INTEGER = 2'd1;
  localparam logic [1:0] K_FLOAT   = 2'd2;
  localparam logic [1:0] K_UNSET   = 2'd3;

  localparam logic [CharWidth-1:0] CH_MINUS = 8'h2d;
  localparam logic [CharWidth-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CharWidth-1:0] CH_DOT   = 8'h2e;
  localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharWidth-1:0] CH_ONE   = 8'h31;
  localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;
  localparam logic [CharWidth-1:0] CH_E_UP  = 8'h45;
  localparam logic [CharWidth-1:0] CH_E_LOW = 8'h65;

  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 has_character;
    logic                 last;
  } char_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [1:0] number_kind;
  } res_item_t;

endpackage

// ===== hw/rtl/json_number_classifier.sv =====
// JSON number checker. Feed the text of one number one character per item, with last set on
// the final character; an empty text is a single item with has_character low. The block
// answers with one result per number: on the last character, or earlier on the first
// character that breaks the grammar, after which the rest of the text up to last is dropped.
// A new item is taken each cycle while results are not stalled. An item passes an input
// register and then the result register, from which its result is offered.
module json_number_classifier
  import jnc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_item_t char_item,
  output logic       res_valid,
  input  logic       res_stall,
  output res_item_t  res_item
);

  logic            q_valid;
  char_item_t      q_item;
  logic [3:0]      phase;
  logic [1:0]      kind;
  logic [3:0]      phase_next;
  logic [1:0]      kind_next;
  logic            emit;
  logic [1:0]      verdict;
  logic            advance;
  logic [3:0]      eff;
  logic            is_digit;
  logic            is_exp;
  logic            is_sign;
  logic            take;
  logic [1:0]      end_verdict;
  logic [3:0]      take_phase;
  logic [1:0]      scan_kind;
  logic [1:0]      scan_verdict;

  assign advance    = q_valid && !(res_valid && res_stall);
  assign char_stall = q_valid && res_valid && res_stall;

  always_comb begin
    is_digit = q_item.character inside {[CH_ZERO:CH_NINE]};
    is_exp   = (q_item.character == CH_E_UP) || (q_item.character == CH_E_LOW);
    is_sign  = (q_item.character == CH_PLUS) || (q_item.character == CH_MINUS);

    eff = phase;
    if (eff == PH_START && q_item.character != CH_MINUS) begin
      eff = PH_FIRST_DIG;
    end
    if (eff == PH_INT_DIGITS && !is_digit) begin
      eff = PH_INT_DONE;
    end
    if (eff == PH_EXP_MARK && !is_sign) begin
      eff = PH_EXP_SIGN;
    end

    take        = 1'b0;
    end_verdict = V_INVALID;
    take_phase  = PH_START;
    scan_kind   = kind;
    case (eff)
      PH_START: begin
        take       = 1'b1;
        take_phase = PH_FIRST_DIG;
      end
      PH_FIRST_DIG: begin
        if (q_item.character == CH_ZERO) begin
          scan_kind   = K_ZERO;
          take        = 1'b1;
          end_verdict = V_OKAY;
          take_phase  = PH_INT_DONE;
        end else if (q_item.character inside {[CH_ONE:CH_NINE]}) begin
          scan_kind   = K_INTEGER;
          take        = 1'b1;
          end_verdict = V_OKAY;
          take_phase  = PH_INT_DIGITS;
        end
      end
      PH_INT_DIGITS: begin
        take        = 1'b1;
        end_verdict = V_OKAY;
        take_phase  = PH_INT_DIGITS;
      end
      PH_INT_DONE: begin
        scan_kind = K_FLOAT;
        if (q_item.character == CH_DOT) begin
          take       = 1'b1;
          take_phase = PH_DOT;
        end else if (is_exp) begin
          take       = 1'b1;
          take_phase = PH_EXP_MARK;
        end
      end
      PH_DOT: begin
        take        = is_digit;
        end_verdict = V_OKAY;
        take_phase  = PH_FRAC;
      end
      PH_FRAC: begin
        if (is_digit) begin
          take        = 1'b1;
          end_verdict = V_OKAY;
          take_phase  = PH_FRAC;
        end else if (is_exp) begin
          take       = 1'b1;
          take_phase = PH_EXP_MARK;
        end
      end
      PH_EXP_MARK: begin
        take       = 1'b1;
        take_phase = PH_EXP_SIGN;
      end
      PH_EXP_SIGN, PH_EXP_DIGITS: begin
        take        = is_digit;
        end_verdict = V_OKAY;
        take_phase  = PH_EXP_DIGITS;
      end
      default: begin
        take = 1'b0;
      end
    endcase

    if (!take) begin
      scan_verdict = V_INVALID;
    end else if (q_item.last) begin
      scan_verdict = end_verdict;
    end else begin
      scan_verdict = V_NONE;
    end

    emit       = 1'b0;
    verdict    = V_EARLY;
    phase_next = PH_START;
    kind_next  = K_UNSET;
    if (!q_item.has_character) begin
      emit    = (phase != PH_SWALLOW);
      verdict = V_EARLY;
      kind_next = kind;
    end else if (phase == PH_SWALLOW) begin
      if (!q_item.last) begin
        phase_next = PH_SWALLOW;
        kind_next  = kind;
      end
    end else if (scan_verdict == V_NONE) begin
      phase_next = take_phase;
      kind_next  = scan_kind;
    end else begin
      emit      = 1'b1;
      verdict   = scan_verdict;
      kind_next = scan_kind;
      if (!q_item.last) begin
        phase_next = PH_SWALLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      res_valid <= 1'b0;
      phase     <= PH_START;
      kind      <= K_UNSET;
    end else begin
      if (!char_stall) begin
        q_valid <= char_valid;
        q_item  <= char_item;
      end
      if (advance) begin
        res_valid <= emit;
        if (emit) begin
          res_item.verdict     <= verdict;
          res_item.number_kind <= kind_next;
        end
        if (emit && !q_item.has_character) begin
          phase <= PH_START;
          kind  <= K_UNSET;
        end else if (emit && q_item.last) begin
          phase <= PH_START;
          kind  <= K_UNSET;
        end else begin
          phase <= phase_next;
          kind  <= phase_next == PH_START ? K_UNSET : kind_next;
        end
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/jnc_checker.sv =====
module jnc_checker
  import jnc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input char_item_t char_item,
  input logic       res_valid,
  input logic       res_stall,
  input res_item_t  res_item
);

  // A result always carries a real verdict.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.verdict != V_NONE)
    else $error("result without a verdict");

  // A number that is accepted as okay has a recorded kind.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.verdict == V_OKAY) |-> res_item.number_kind != K_UNSET)
    else $error("okay verdict with unset kind");

  // Reset leaves no result pending and the input open.
  assert property (@(posedge clk) rst |=> (!res_valid && !char_stall))
    else $error("pending work after reset");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_item)))
    else $error("stalled result changed");

  // A stalled input item stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_stall) |=> (char_valid && $stable(char_item)))
    else $error("stalled input item changed");

endmodule

bind json_number_classifier jnc_checker u_jnc_checker (
  .clk       (clk),
  .rst       (rst),
  .char_valid(char_valid),
  .char_stall(char_stall),
  .char_item (char_item),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);

// ===== tb/tb_json_number_classifier.sv =====
`timescale 1ns / 1ps

module tb_json_number_classifier;
  import jnc_pkg::*;

  typedef struct packed {
    char_item_t item;
    logic       pinned;
    logic       pinned_has;
    logic [1:0] pinned_verdict;
    logic [1:0] pinned_kind;
  } stim_row_t;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_PATTERN
  } stall_style_t;

  localparam int DirectedRows = 26;
  localparam int RandomItems = 950;

  localparam stim_row_t DirectedTable [DirectedRows] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, 1'b1, V_EARLY, K_UNSET},
    '{'{CH_ZERO, 1'b1, 1'b1}, 1'b1, 1'b1, V_OKAY, K_ZERO},
    '{'{8'hff, 1'b1, 1'b1}, 1'b1, 1'b1, V_INVALID, K_UNSET},
    '{'{CH_MINUS, 1'b1, 1'b1}, 1'b1, 1'b1, V_INVALID, K_UNSET},
    '{'{8'h3a, 1'b1, 1'b1}, 1'b1, 1'b1, V_INVALID, K_UNSET},
    '{'{CH_MINUS, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{CH_NINE, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{CH_DOT, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{8'h35, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{CH_E_LOW, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{CH_PLUS, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{8'h37, 1'b1, 1'b1}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{CH_ZERO, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{CH_E_UP, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{CH_MINUS, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{8'h33, 1'b1, 1'b1}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{CH_ONE, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{8'h78, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{CH_NINE, 1'b1, 1'b1}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{CH_ONE, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{8'h61, 1'b1, 1'b0}, 1'b1, 1'b1, V_INVALID, K_UNSET},
    '{'{8'h80, 1'b0, 1'b1}, 1'b1, 1'b0, V_NONE, K_UNSET},
    '{'{8'h55, 1'b0, 1'b0}, 1'b1, 1'b1, V_EARLY, K_UNSET},
    '{'{CH_ONE, 1'b1, 1'b0}, 1'b0, 1'b0, V_NONE, K_UNSET},
    '{'{CH_DOT, 1'b1, 1'b1}, 1'b0, 1'b0, V_NONE, K_UNSET}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       char_valid;
  logic       char_stall;
  char_item_t char_item;
  logic       res_valid;
  logic       res_stall;
  res_item_t  res_item;

  stim_row_t  stimulus[$];
  res_item_t  expected_results[$];
  int         items_accepted = 0;
  int         mismatch_count = 0;

  logic [3:0] grammar_phase = PH_START;
  logic [1:0] recorded_kind = K_UNSET;

  json_number_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_item (char_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic bit is_decimal(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void restart_number();
    grammar_phase = PH_START;
    recorded_kind = K_UNSET;
  endfunction

  function automatic logic [1:0] take_char(logic last, logic [1:0] end_verdict,
                                           logic [3:0] next_phase);
    if (last) begin
      return end_verdict;
    end
    grammar_phase = next_phase;
    return V_NONE;
  endfunction

  function automatic logic [1:0] scan_char(logic [7:0] c, logic last);
    logic [3:0] ph;
    logic [1:0] v;
    bit         settled;
    ph = grammar_phase;
    v = V_INVALID;
    settled = 1'b0;
    while (!settled) begin
      settled = 1'b1;
      case (ph)
        PH_START: begin
          if (c == CH_MINUS) begin
            v = take_char(last, V_INVALID, PH_FIRST_DIG);
          end else begin
            ph = PH_FIRST_DIG;
            settled = 1'b0;
          end
        end
        PH_FIRST_DIG: begin
          if (c == CH_ZERO) begin
            recorded_kind = K_ZERO;
            v = take_char(last, V_OKAY, PH_INT_DONE);
          end else if (c >= CH_ONE && c <= CH_NINE) begin
            recorded_kind = K_INTEGER;
            v = take_char(last, V_OKAY, PH_INT_DIGITS);
          end else begin
            v = V_INVALID;
          end
        end
        PH_INT_DIGITS: begin
          if (is_decimal(c)) begin
            v = take_char(last, V_OKAY, PH_INT_DIGITS);
          end else begin
            ph = PH_INT_DONE;
            settled = 1'b0;
          end
        end
        PH_INT_DONE: begin
          recorded_kind = K_FLOAT;
          if (c == CH_DOT) begin
            v = take_char(last, V_INVALID, PH_DOT);
          end else if (c == CH_E_UP || c == CH_E_LOW) begin
            v = take_char(last, V_INVALID, PH_EXP_MARK);
          end else begin
            v = V_INVALID;
          end
        end
        PH_DOT: begin
          if (is_decimal(c)) begin
            v = take_char(last, V_OKAY, PH_FRAC);
          end else begin
            v = V_INVALID;
          end
        end
        PH_FRAC: begin
          if (is_decimal(c)) begin
            v = take_char(last, V_OKAY, PH_FRAC);
          end else if (c == CH_E_UP || c == CH_E_LOW) begin
            v = take_char(last, V_INVALID, PH_EXP_MARK);
          end else begin
            v = V_INVALID;
          end
        end
        PH_EXP_MARK: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            v = take_char(last, V_INVALID, PH_EXP_SIGN);
          end else begin
            ph = PH_EXP_SIGN;
            settled = 1'b0;
          end
        end
        PH_EXP_SIGN, PH_EXP_DIGITS: begin
          if (is_decimal(c)) begin
            v = take_char(last, V_OKAY, PH_EXP_DIGITS);
          end else begin
            v = V_INVALID;
          end
        end
        default: begin
          v = V_INVALID;
        end
      endcase
    end
    return v;
  endfunction

  // Advances the grammar state by one item and tells whether it yields a verdict.
  task automatic classify_char(input char_item_t it, output bit produced,
                               output res_item_t result);
    logic [1:0] v;
    produced = 1'b0;
    result = '0;
    if (!it.has_character) begin
      if (grammar_phase != PH_SWALLOW) begin
        produced = 1'b1;
        result.verdict = V_EARLY;
        result.number_kind = recorded_kind;
      end
      restart_number();
    end else if (grammar_phase == PH_SWALLOW) begin
      if (it.last) begin
        restart_number();
      end
    end else begin
      v = scan_char(it.character, it.last);
      if (v != V_NONE || it.last) begin
        produced = 1'b1;
        result.verdict = (v == V_NONE) ? V_EARLY : v;
        result.number_kind = recorded_kind;
        if (it.last) begin
          restart_number();
        end else begin
          grammar_phase = PH_SWALLOW;
        end
      end
    end
  endtask

  task automatic push_char(logic [7:0] c, logic has, logic last);
    stim_row_t row;
    row = '0;
    row.item = '{c, has, last};
    stimulus.push_back(row);
  endtask

  task automatic add_random_text();
    logic [7:0]  text[$];
    int unsigned shape;
    int unsigned cut;
    int unsigned keep;
    shape = $urandom_range(0, 99);
    if (shape >= 94) begin
      push_char(8'($urandom), 1'b0, 1'($urandom));
      return;
    end
    if (shape >= 88) begin
      repeat ($urandom_range(1, 5)) text.push_back(8'($urandom));
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        text.push_back(CH_MINUS);
      end
      if ($urandom_range(0, 3) == 0) begin
        text.push_back(CH_ZERO);
      end else begin
        text.push_back(CH_ONE + 8'($urandom_range(0, 8)));
        repeat ($urandom_range(0, 4)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 1) == 1) begin
        text.push_back(CH_DOT);
        repeat ($urandom_range(1, 4)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 1) == 1) begin
        text.push_back($urandom_range(0, 1) ? CH_E_UP : CH_E_LOW);
        case ($urandom_range(0, 2))
          0: text.push_back(CH_PLUS);
          1: text.push_back(CH_MINUS);
          default: ;
        endcase
        repeat ($urandom_range(1, 3)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ((shape >= 60 && shape < 75) || (shape >= 80 && shape < 84)) begin
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
      end
      if (shape >= 75 && shape < 80 && text.size() > 1) begin
        keep = $urandom_range(1, text.size() - 1);
        while (text.size() > keep) void'(text.pop_back());
      end
    end
    cut = (shape >= 80 && shape < 88) ? $urandom_range(0, text.size() - 1) : text.size();
    for (int i = 0; i < cut; i++) begin
      push_char(text[i], 1'b1, i == text.size() - 1);
    end
    if (cut < text.size()) begin
      push_char(8'($urandom), 1'b0, 1'($urandom));
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    stim_row_t row;
    bit        produced;
    res_item_t predicted;
    res_item_t oldest;
    if (!rst) begin
      if (char_valid && !char_stall) begin
        row = stimulus[items_accepted];
        classify_char(char_item, produced, predicted);
        if (row.pinned) begin
          produced = row.pinned_has;
          predicted = '{row.pinned_verdict, row.pinned_kind};
        end
        if (produced) begin
          expected_results.push_back(predicted);
        end
        items_accepted++;
      end
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with no item waiting for one",
                                    res_item.verdict, res_item.number_kind));
        end else begin
          oldest = expected_results.pop_front();
          if (res_item.verdict !== oldest.verdict) begin
            report_mismatch($sformatf("verdict %0d, expected %0d",
                                      res_item.verdict, oldest.verdict));
          end
          if (res_item.number_kind !== oldest.number_kind) begin
            report_mismatch($sformatf("number_kind %0d, expected %0d",
                                      res_item.number_kind, oldest.number_kind));
          end
        end
      end
    end
  end

  // The receiver stalls in segments of varying style, and once holds off long
  // enough for the block to fill up and stall its input.
  initial begin : receiver
    int unsigned  span;
    int unsigned  tick;
    stall_style_t style;
    bit           held_off;
    held_off = 1'b0;
    tick = 0;
    forever begin
      if (!held_off && items_accepted >= 400) begin
        held_off = 1'b1;
        res_stall <= 1'b1;
        repeat (64) @(posedge clk);
      end
      span = $urandom_range(10, 80);
      style = stall_style_t'($urandom_range(0, 3));
      repeat (span) begin
        case (style)
          STALL_NONE:  res_stall <= 1'b0;
          STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
          STALL_HALF:  res_stall <= 1'($urandom_range(0, 1));
          default:     res_stall <= (tick % 5) < 2;
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  initial begin : sender
    int idx;
    int burst_left;
    int gap;
    char_valid <= 1'b0;
    char_item <= '0;
    for (int i = 0; i < DirectedRows; i++) begin
      stimulus.push_back(DirectedTable[i]);
    end
    while (stimulus.size() < DirectedRows + RandomItems) add_random_text();

    @(posedge clk);
    while (rst) @(posedge clk);

    idx = 0;
    burst_left = $urandom_range(1, 20);
    while (idx < stimulus.size()) begin
      char_valid <= 1'b1;
      char_item <= stimulus[idx].item;
      do @(posedge clk); while (char_stall);
      idx++;
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        if (gap > 0) begin
          char_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                                 : $urandom_range(1, 20);
      end
    end
    char_valid <= 1'b0;

    do @(posedge clk); while (expected_results.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("json_number_classifier regression: pass");
    end else begin
      $display("json_number_classifier regression: fail");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("json_number_classifier regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/jnc_pkg.sv
hw/rtl/json_number_classifier.sv
hw/rtl/jnc_checker.sv
tb/tb_json_number_classifier.sv
